// File: sv/vu_bar_pkg.sv
// package for the vu bar column animator
// holds the transfer structs, sizing constants, register indexes and row mask helper
// no dependencies
`default_nettype none

package vu_bar_pkg;

    localparam int COLUMNS = 10;
    localparam int ROWS    = 6;

    localparam int COL_W    = 4;
    localparam int LEVEL_W  = 4;
    localparam int COUNT_W  = 4;
    localparam int TICK_W   = 11;
    localparam int BRIGHT_W = 8;
    localparam int ROWMASK_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // column index into the per-column state
    localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    // wide enough to compare a column number against the column count
    localparam int COLCMP_W = 6;

    localparam logic [TICK_W-1:0] MUTE_PERIOD = TICK_W'(16);
    localparam logic [COUNT_W-1:0] FULL_DROP = COUNT_W'(3);
    localparam logic [LEVEL_W-1:0] ROWS_LVL = LEVEL_W'(ROWS);
    localparam logic [COUNT_W-1:0] FULL_ROWS = COUNT_W'(15);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME_STEP     = 2'd0,
        CFG_MAX_BRIGHTNESS  = 2'd1,
        CFG_MUTE_BRIGHTNESS = 2'd2,
        CFG_MUTE_LEVEL      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] average_level;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]     out_column;
        logic                 redraw;
        logic [ROWMASK_W-1:0] lit_rows;
        logic [BRIGHT_W-1:0]  lit_brightness;
        logic [COUNT_W-1:0]   bar_height;
    } out_item_t;

    // bit i set for every row i below the bar height
    function automatic logic [ROWMASK_W-1:0] bar_rows(input logic [COUNT_W-1:0] h);
        logic [ROWMASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < ROWMASK_W; i++) begin
            if ((i < ROWS) && (COUNT_W'(i) < h)) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: sv/vu_bar_column_animator.sv
// top level of the vu bar column animator
// per-column bar state, input register, update logic and result register
// depends on vu_bar_pkg
`default_nettype none

// One transfer on s_ is one tick for one LED column and yields exactly one transfer
// on m_, through the input register and then the result register. A new tick is
// taken every cycle unless m_valid is held with m_ready low; the per-column state is
// read and written back in the single update stage, so ticks for the same column may
// follow back to back. The configuration registers are written through
// cfg_wr_en/cfg_index/cfg_data and should only change while no tick is in flight.
// Columns >= COLUMNS leave all state alone; the result is zero but out_column.
module vu_bar_column_animator (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire vu_bar_pkg::in_item_t                 s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output vu_bar_pkg::out_item_t                     m_data,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [vu_bar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vu_bar_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int TW = vu_bar_pkg::TICK_W;
    localparam int CW = vu_bar_pkg::COUNT_W;
    localparam int LW = vu_bar_pkg::LEVEL_W;
    localparam int BW = vu_bar_pkg::BRIGHT_W;
    localparam int NC = vu_bar_pkg::COLUMNS;

    // configuration
    logic [BW-1:0] volume_step_reg;
    logic [BW-1:0] max_brightness_reg;
    logic [BW-1:0] mute_brightness_reg;
    logic [LW-1:0] mute_level_reg;

    // per-column state
    logic [CW-1:0] bar_count_reg   [NC];
    logic [CW-1:0] bar_target_reg  [NC];
    logic [TW-1:0] tick_count_reg  [NC];
    logic [TW-1:0] tick_period_reg [NC];

    // pipeline
    logic                  in_valid_reg;
    vu_bar_pkg::in_item_t  in_item_reg;
    logic                  out_valid_reg;
    vu_bar_pkg::out_item_t out_item_reg;
    vu_bar_pkg::out_item_t out_item_next;

    logic advance;
    logic in_range;
    logic state_we;
    logic [vu_bar_pkg::COLCMP_W-1:0] col_ext;
    logic [vu_bar_pkg::IDX_W-1:0]    idx;

    logic [CW-1:0] cur_count;
    logic [CW-1:0] cur_target;
    logic [TW-1:0] cur_tick;
    logic [TW-1:0] cur_period;
    logic [CW-1:0] count_next;
    logic [CW-1:0] target_next;
    logic [TW-1:0] tick_next;
    logic [TW-1:0] period_next;

    logic [LW-1:0] lvl;
    logic [CW-1:0] level_dist;
    logic [BW-1:0] p_base;
    logic [TW-1:0] p_calc;
    logic [TW-1:0] tick_try;
    logic          fired;

    function automatic logic [TW-1:0] tick_step(input logic [TW-1:0] cnt,
                                                input logic [TW-1:0] per);
        logic [TW-1:0] n;
        n = cnt + TW'(1);
        if (n >= per) begin
            n = '0;
        end
        return n;
    endfunction

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    assign col_ext  = vu_bar_pkg::COLCMP_W'(in_item_reg.column);
    assign in_range = (col_ext < vu_bar_pkg::COLCMP_W'(NC));
    assign idx      = col_ext[vu_bar_pkg::IDX_W-1:0];
    assign state_we = in_valid_reg && advance && in_range;
    assign lvl      = in_item_reg.level;

    // state read, guarded so an out-of-range column never indexes past the array
    always_comb begin
        if (in_range) begin
            cur_count  = bar_count_reg[idx];
            cur_target = bar_target_reg[idx];
            cur_tick   = tick_count_reg[idx];
            cur_period = tick_period_reg[idx];
        end else begin
            cur_count  = '0;
            cur_target = '0;
            cur_tick   = '0;
            cur_period = '0;
        end
    end

    // period from distance between the old target and the level, times seven when the level is below the average
    always_comb begin
        level_dist = (cur_target > lvl) ? (cur_target - lvl) : (lvl - cur_target);
        p_base = (volume_step_reg > BW'(level_dist)) ?
                 (volume_step_reg - BW'(level_dist)) : '0;
        if (lvl < in_item_reg.average_level) begin
            p_calc = (TW'(p_base) << 3) - TW'(p_base);
        end else begin
            p_calc = TW'(p_base);
        end
    end

    always_comb begin
        count_next  = cur_count;
        target_next = cur_target;
        tick_next   = cur_tick;
        period_next = cur_period;
        tick_try    = '0;
        fired       = 1'b0;
        out_item_next = '0;
        out_item_next.out_column = in_item_reg.column;

        if (in_range) begin
            if (lvl != mute_level_reg) begin
                if (cur_count < cur_target) begin
                    if (lvl > cur_target) begin
                        period_next = p_calc;
                        target_next = lvl;
                    end
                    tick_try  = tick_step(cur_tick, period_next);
                    tick_next = tick_try;
                    if (tick_try == '0) begin
                        count_next = cur_count + CW'(1);
                        fired      = 1'b1;
                    end
                end else if (cur_count > cur_target) begin
                    if (lvl < cur_target) begin
                        period_next = p_calc;
                        target_next = lvl;
                    end
                    tick_try  = tick_step(cur_tick, period_next);
                    tick_next = tick_try;
                    if (tick_try == '0) begin
                        count_next = cur_count - CW'(1);
                        fired      = 1'b1;
                    end
                end else begin
                    period_next = p_calc;
                    if (lvl == cur_target) begin
                        // full-height hold pulls the target down
                        if (lvl == vu_bar_pkg::ROWS_LVL) begin
                            target_next = lvl - vu_bar_pkg::FULL_DROP;
                        end
                    end else begin
                        target_next = lvl;
                    end
                end
                if (fired) begin
                    out_item_next.redraw         = 1'b1;
                    out_item_next.lit_rows       = vu_bar_pkg::bar_rows(count_next);
                    out_item_next.lit_brightness = max_brightness_reg;
                end
            end else begin
                // mute: bar untouched, whole column at mute brightness on a tick
                tick_try  = tick_step(cur_tick, cur_period);
                tick_next = tick_try;
                if (tick_try == '0) begin
                    period_next                  = vu_bar_pkg::MUTE_PERIOD;
                    out_item_next.redraw         = 1'b1;
                    out_item_next.lit_rows       = vu_bar_pkg::bar_rows(vu_bar_pkg::FULL_ROWS);
                    out_item_next.lit_brightness = mute_brightness_reg;
                end
            end
            out_item_next.bar_height = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_step_reg     <= BW'(16);
            max_brightness_reg  <= BW'(255);
            mute_brightness_reg <= BW'(32);
            mute_level_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (vu_bar_pkg::cfg_index_t'(cfg_index))
                vu_bar_pkg::CFG_VOLUME_STEP:     volume_step_reg     <= cfg_data;
                vu_bar_pkg::CFG_MAX_BRIGHTNESS:  max_brightness_reg  <= cfg_data;
                vu_bar_pkg::CFG_MUTE_BRIGHTNESS: mute_brightness_reg <= cfg_data;
                vu_bar_pkg::CFG_MUTE_LEVEL:      mute_level_reg      <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NC; i++) begin
                bar_count_reg[i]   <= '0;
                bar_target_reg[i]  <= '0;
                tick_count_reg[i]  <= '0;
                tick_period_reg[i] <= '0;
            end
        end else if (state_we) begin
            bar_count_reg[idx]   <= count_next;
            bar_target_reg[idx]  <= target_next;
            tick_count_reg[idx]  <= tick_next;
            tick_period_reg[idx] <= period_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
        if (advance && in_valid_reg) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

`default_nettype wire
